FILE: rtl/hpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpl_pkg
// Shared types, constants and width helpers of the Hall position linearizer.
// ----------------------------------------------------------------------------
package hpl_pkg;

    localparam int Z_W        = 16;
    localparam int POS_W      = 16;
    localparam int QW         = 16;
    localparam int MA_W       = 18;
    localparam int DEN_W      = 18;
    localparam int V_W        = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int FRAC_BITS_DEF = 8;

    localparam int FIX_OFFSET = 2000;
    localparam int FIX_SPAN   = 4000;
    localparam int CLUTCH_MM  = 10;
    localparam int GEAR_MM    = 26;
    localparam int MIN_GAP    = 10;

    localparam logic [15:0] STROKE_RST = 16'd6656;

    localparam logic signed [POS_W-1:0] POS_MAX = 16'sh7FFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 16'sh8000;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLUTCH_KIND = 3'd0,
        REG_CAL_VALID   = 3'd1,
        REG_Z_LOW       = 3'd2,
        REG_Z_HIGH      = 3'd3,
        REG_Z_MIDDLE    = 3'd4,
        REG_STROKE_LEN  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic                    clutch_kind;
        logic                    cal_valid;
        logic signed [Z_W-1:0]   z_low;
        logic signed [Z_W-1:0]   z_high;
        logic signed [Z_W-1:0]   z_middle;
        logic        [15:0]      stroke_len;
    } t_cfg;

    typedef struct packed {
        logic zero_res;
        logic div_zero;
    } t_flags;

    function automatic int mb_width(input int fb);
        return (fb + 6 > 17) ? fb + 6 : 17;
    endfunction

    function automatic int num_width(input int fb);
        return MA_W + mb_width(fb);
    endfunction

endpackage

FILE: rtl/hpl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpl_front
// Front end: takes raw samples, selects the map segment and forms the
// numerator product and denominator of the rounding division.
// ----------------------------------------------------------------------------
module hpl_front #(
    parameter int FRAC_BITS = hpl_pkg::FRAC_BITS_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  hpl_pkg::t_cfg                                     i_cfg,
    input  logic                                              i_in_valid,
    output logic                                              o_in_stall,
    input  logic signed [hpl_pkg::Z_W-1:0]                    i_raw_z,
    input  logic                                              i_q_full,
    output logic                                              o_push,
    output logic signed [hpl_pkg::num_width(FRAC_BITS)-1:0]   o_num,
    output logic signed [hpl_pkg::DEN_W-1:0]                  o_den,
    output hpl_pkg::t_flags                                   o_flags
);

    localparam int MA_W  = hpl_pkg::MA_W;
    localparam int MB_W  = hpl_pkg::mb_width(FRAC_BITS);
    localparam int NUM_W = hpl_pkg::num_width(FRAC_BITS);
    localparam int DEN_W = hpl_pkg::DEN_W;
    localparam int Z_W   = hpl_pkg::Z_W;

    localparam logic signed [MB_W-1:0]  MB_CLUTCH = MB_W'(hpl_pkg::CLUTCH_MM << FRAC_BITS);
    localparam logic signed [MB_W-1:0]  MB_GEAR   = MB_W'(hpl_pkg::GEAR_MM << FRAC_BITS);
    localparam logic signed [MA_W-1:0]  FIX_OFF   = MA_W'(hpl_pkg::FIX_OFFSET);
    localparam logic signed [DEN_W-1:0] DEN_FIX   = DEN_W'(hpl_pkg::FIX_SPAN);
    localparam logic signed [MA_W-1:0]  GAP       = MA_W'(hpl_pkg::MIN_GAP);
    localparam logic signed [MA_W-1:0]  NGAP      = -GAP;

    logic                    fe;

    logic                    r_a_valid;
    logic signed [Z_W-1:0]   r_a_z;

    logic                    r_b_valid;
    logic signed [MA_W-1:0]  r_b_ma;
    logic signed [MB_W-1:0]  r_b_mb;
    logic signed [DEN_W-1:0] r_b_den;
    hpl_pkg::t_flags         r_b_flags;

    logic                    r_c_valid;
    logic signed [NUM_W-1:0] r_c_num;
    logic signed [DEN_W-1:0] r_c_den;
    hpl_pkg::t_flags         r_c_flags;

    logic signed [MA_W-1:0]  z_e;
    logic signed [MA_W-1:0]  lo_e;
    logic signed [MA_W-1:0]  hi_e;
    logic signed [MA_W-1:0]  mid_e;
    logic signed [MA_W-1:0]  mid_lo;
    logic signed [MA_W-1:0]  span;
    logic signed [MB_W-1:0]  s_e;
    logic                    mid_near;
    logic                    span_small;

    logic signed [MA_W-1:0]  n_ma;
    logic signed [MB_W-1:0]  n_mb;
    logic signed [DEN_W-1:0] n_den;
    hpl_pkg::t_flags         n_flags;
    logic signed [NUM_W-1:0] prod;

    assign fe         = !(r_c_valid && i_q_full);
    assign o_in_stall = !fe;
    assign o_push     = r_c_valid && !i_q_full;
    assign o_num      = r_c_num;
    assign o_den      = r_c_den;
    assign o_flags    = r_c_flags;

    assign z_e        = MA_W'(r_a_z);
    assign lo_e       = MA_W'(i_cfg.z_low);
    assign hi_e       = MA_W'(i_cfg.z_high);
    assign mid_e      = MA_W'(i_cfg.z_middle);
    assign mid_lo     = mid_e - lo_e;
    assign span       = hi_e - lo_e;
    assign s_e        = MB_W'($signed({1'b0, i_cfg.stroke_len}));
    assign mid_near   = (mid_lo < GAP) && (mid_lo > NGAP);
    assign span_small = (span < GAP) && (span > NGAP);

    always_comb begin
        n_ma    = '0;
        n_mb    = '0;
        n_den   = DEN_W'(1);
        n_flags = '0;
        if (i_cfg.clutch_kind || !i_cfg.cal_valid) begin
            n_ma  = z_e + FIX_OFF;
            n_mb  = i_cfg.clutch_kind ? MB_CLUTCH : MB_GEAR;
            n_den = DEN_FIX;
        end else if (i_cfg.z_middle == '0 || mid_near) begin
            if (span_small) begin
                n_flags.zero_res = 1'b1;
            end else begin
                n_ma  = z_e - lo_e;
                n_mb  = s_e;
                n_den = span;
            end
        end else if (i_cfg.z_low < i_cfg.z_high) begin
            if (r_a_z <= i_cfg.z_middle) begin
                n_ma  = z_e - lo_e;
                n_mb  = s_e;
                n_den = mid_lo <<< 1;
            end else if (i_cfg.z_high == i_cfg.z_middle) begin
                n_flags.div_zero = 1'b1;
            end else begin
                n_ma  = hi_e + z_e - (mid_e <<< 1);
                n_mb  = s_e;
                n_den = (hi_e - mid_e) <<< 1;
            end
        end else begin
            if (r_a_z >= i_cfg.z_middle) begin
                n_ma  = lo_e - z_e;
                n_mb  = s_e;
                n_den = (lo_e - mid_e) <<< 1;
            end else if (i_cfg.z_high == i_cfg.z_middle) begin
                n_flags.div_zero = 1'b1;
            end else begin
                n_ma  = (mid_e <<< 1) - hi_e - z_e;
                n_mb  = s_e;
                n_den = (mid_e - hi_e) <<< 1;
            end
        end
    end

    assign prod = NUM_W'(r_b_ma * r_b_mb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (fe) begin
            r_a_valid <= i_in_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_a_z     <= i_raw_z;
            r_b_ma    <= n_ma;
            r_b_mb    <= n_mb;
            r_b_den   <= n_den;
            r_b_flags <= n_flags;
            r_c_num   <= prod;
            r_c_den   <= r_b_den;
            r_c_flags <= r_b_flags;
        end
    end

endmodule

FILE: rtl/hpl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpl_queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module hpl_queue #(
    parameter int W = 56
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);

    localparam int DEPTH = hpl_pkg::Q_DEPTH;
    localparam int PTR_W = hpl_pkg::Q_PTR_W;

    logic [W-1:0]   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/hpl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpl_back
// Back end: pipelined round-to-nearest division, one quotient bit per stage,
// then saturation to the 16-bit position and the output register.
// ----------------------------------------------------------------------------
module hpl_back #(
    parameter int FRAC_BITS = hpl_pkg::FRAC_BITS_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_valid,
    output logic                                              o_pop,
    input  logic signed [hpl_pkg::num_width(FRAC_BITS)-1:0]   i_num,
    input  logic signed [hpl_pkg::DEN_W-1:0]                  i_den,
    input  hpl_pkg::t_flags                                   i_flags,
    output logic                                              o_out_valid,
    input  logic                                              i_out_stall,
    output logic signed [hpl_pkg::POS_W-1:0]                  o_position,
    output logic                                              o_saturated
);

    localparam int NUM_W = hpl_pkg::num_width(FRAC_BITS);
    localparam int DEN_W = hpl_pkg::DEN_W;
    localparam int V_W   = hpl_pkg::V_W;
    localparam int QW    = hpl_pkg::QW;
    localparam int POS_W = hpl_pkg::POS_W;
    localparam int D_W   = NUM_W + 2;
    localparam int H_W   = D_W - QW;

    localparam logic [QW-1:0] Q_POS_LIM = QW'(hpl_pkg::POS_MAX);
    localparam logic [QW-1:0] Q_NEG_LIM = QW'(hpl_pkg::POS_MAX) + QW'(1);

    logic                 be;

    logic                 r_p1_valid;
    logic [NUM_W-1:0]     r_p1_a;
    logic [DEN_W-1:0]     r_p1_dabs;
    logic                 r_p1_neg;
    hpl_pkg::t_flags      r_p1_flags;

    logic                 r_p2_valid;
    logic [D_W-1:0]       r_p2_d;
    logic [V_W-1:0]       r_p2_v;
    logic                 r_p2_neg;
    hpl_pkg::t_flags      r_p2_flags;

    logic                 r_dv_valid [QW+1];
    logic [V_W-1:0]       r_dv_rem   [QW+1];
    logic [QW-1:0]        r_dv_low   [QW+1];
    logic [QW-1:0]        r_dv_q     [QW+1];
    logic [V_W-1:0]       r_dv_v     [QW+1];
    logic                 r_dv_neg   [QW+1];
    logic                 r_dv_ovf   [QW+1];
    hpl_pkg::t_flags      r_dv_flags [QW+1];

    logic [V_W:0]         trial      [QW];
    logic                 take       [QW];
    logic [V_W-1:0]       n_rem      [QW];

    logic [H_W-1:0]       p2_high;
    logic                 p2_ovf;

    logic                 r_out_valid;
    logic signed [POS_W-1:0] r_out_pos;
    logic                 r_out_sat;
    logic signed [POS_W-1:0] n_pos;
    logic                 n_sat;
    logic [QW-1:0]        fin_q;
    hpl_pkg::t_flags      fin_flags;

    assign be          = !r_out_valid || !i_out_stall;
    assign o_pop       = be && i_valid;
    assign o_out_valid = r_out_valid;
    assign o_position  = r_out_pos;
    assign o_saturated = r_out_sat;

    assign p2_high = r_p2_d[D_W-1:QW];
    assign p2_ovf  = (p2_high >= H_W'(r_p2_v));

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            trial[k] = {r_dv_rem[k], r_dv_low[k][QW-1]};
            take[k]  = (trial[k] >= {1'b0, r_dv_v[k]});
            n_rem[k] = take[k] ? V_W'(trial[k] - {1'b0, r_dv_v[k]}) : V_W'(trial[k]);
        end
    end

    assign fin_q     = r_dv_q[QW];
    assign fin_flags = r_dv_flags[QW];

    always_comb begin
        n_pos = '0;
        n_sat = 1'b0;
        if (fin_flags.zero_res) begin
            n_pos = '0;
        end else if (fin_flags.div_zero) begin
            n_pos = hpl_pkg::POS_MAX;
            n_sat = 1'b1;
        end else if (!r_dv_neg[QW]) begin
            if (r_dv_ovf[QW] || fin_q > Q_POS_LIM) begin
                n_pos = hpl_pkg::POS_MAX;
                n_sat = 1'b1;
            end else begin
                n_pos = $signed(fin_q);
            end
        end else begin
            if (r_dv_ovf[QW] || fin_q > Q_NEG_LIM) begin
                n_pos = hpl_pkg::POS_MIN;
                n_sat = 1'b1;
            end else begin
                n_pos = $signed(QW'(~fin_q + QW'(1)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k <= QW; k++) begin
                r_dv_valid[k] <= 1'b0;
            end
        end else if (be) begin
            r_p1_valid    <= i_valid;
            r_p2_valid    <= r_p1_valid;
            r_dv_valid[0] <= r_p2_valid;
            for (int k = 0; k < QW; k++) begin
                r_dv_valid[k+1] <= r_dv_valid[k];
            end
            r_out_valid   <= r_dv_valid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (be) begin
            r_p1_a     <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_p1_dabs  <= i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
            r_p1_neg   <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_p1_flags <= i_flags;

            r_p2_d     <= D_W'({r_p1_a, 1'b0}) + D_W'(r_p1_dabs);
            r_p2_v     <= {r_p1_dabs[V_W-2:0], 1'b0};
            r_p2_neg   <= r_p1_neg;
            r_p2_flags <= r_p1_flags;

            r_dv_rem[0]   <= p2_ovf ? '0 : V_W'(p2_high);
            r_dv_low[0]   <= r_p2_d[QW-1:0];
            r_dv_q[0]     <= '0;
            r_dv_v[0]     <= r_p2_v;
            r_dv_neg[0]   <= r_p2_neg;
            r_dv_ovf[0]   <= p2_ovf;
            r_dv_flags[0] <= r_p2_flags;

            for (int k = 0; k < QW; k++) begin
                r_dv_rem[k+1]   <= n_rem[k];
                r_dv_low[k+1]   <= {r_dv_low[k][QW-2:0], 1'b0};
                r_dv_q[k+1]     <= {r_dv_q[k][QW-2:0], take[k]};
                r_dv_v[k+1]     <= r_dv_v[k];
                r_dv_neg[k+1]   <= r_dv_neg[k];
                r_dv_ovf[k+1]   <= r_dv_ovf[k];
                r_dv_flags[k+1] <= r_dv_flags[k];
            end

            r_out_pos <= n_pos;
            r_out_sat <= n_sat;
        end
    end

endmodule

FILE: rtl/hall_position_linearizer.sv
`timescale 1ns / 1ps
// Throughput: one sample per cycle while the output is not stalled; the 16-stage divider
// pipeline takes a new quotient each cycle unless stalled, and the 4-entry queue absorbs output stalls.
// Reset: synchronous, active low; clears all valid bits, queue pointers and the
// configuration registers (stroke length 26 mm, all others zero).
// ----------------------------------------------------------------------------
// hall_position_linearizer
// Maps a raw Hall Z reading to a saturated piston position in fixed point.
// ----------------------------------------------------------------------------
module hall_position_linearizer #(
    parameter int FRAC_BITS = hpl_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [hpl_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [hpl_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [hpl_pkg::Z_W-1:0]        i_raw_z,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [hpl_pkg::POS_W-1:0]      o_position,
    output logic                                  o_saturated
);

    localparam int NUM_W = hpl_pkg::num_width(FRAC_BITS);
    localparam int DEN_W = hpl_pkg::DEN_W;
    localparam int FL_W  = $bits(hpl_pkg::t_flags);
    localparam int QD_W  = NUM_W + DEN_W + FL_W;

    hpl_pkg::t_cfg           r_cfg;

    logic                    q_push;
    logic                    q_pop;
    logic                    q_full;
    logic                    q_empty;
    logic [QD_W-1:0]         q_din;
    logic [QD_W-1:0]         q_dout;

    logic signed [NUM_W-1:0] fr_num;
    logic signed [DEN_W-1:0] fr_den;
    hpl_pkg::t_flags         fr_flags;

    logic signed [NUM_W-1:0] bk_num;
    logic signed [DEN_W-1:0] bk_den;
    hpl_pkg::t_flags         bk_flags;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clutch_kind <= 1'b0;
            r_cfg.cal_valid   <= 1'b0;
            r_cfg.z_low       <= '0;
            r_cfg.z_high      <= '0;
            r_cfg.z_middle    <= '0;
            r_cfg.stroke_len  <= hpl_pkg::STROKE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (hpl_pkg::t_reg_idx'(i_cfg_index))
                hpl_pkg::REG_CLUTCH_KIND: r_cfg.clutch_kind <= i_cfg_data[0];
                hpl_pkg::REG_CAL_VALID:   r_cfg.cal_valid   <= i_cfg_data[0];
                hpl_pkg::REG_Z_LOW:       r_cfg.z_low       <= $signed(i_cfg_data);
                hpl_pkg::REG_Z_HIGH:      r_cfg.z_high      <= $signed(i_cfg_data);
                hpl_pkg::REG_Z_MIDDLE:    r_cfg.z_middle    <= $signed(i_cfg_data);
                hpl_pkg::REG_STROKE_LEN:  r_cfg.stroke_len  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    hpl_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_raw_z    (i_raw_z),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_num      (fr_num),
        .o_den      (fr_den),
        .o_flags    (fr_flags)
    );

    assign q_din = {fr_num, fr_den, fr_flags};

    hpl_queue #(
        .W (QD_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_din),
        .i_pop   (q_pop),
        .o_data  (q_dout),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign bk_num   = $signed(q_dout[QD_W-1 -: NUM_W]);
    assign bk_den   = $signed(q_dout[FL_W +: DEN_W]);
    assign bk_flags = hpl_pkg::t_flags'(q_dout[FL_W-1:0]);

    hpl_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!q_empty),
        .o_pop       (q_pop),
        .i_num       (bk_num),
        .i_den       (bk_den),
        .i_flags     (bk_flags),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_position  (o_position),
        .o_saturated (o_saturated)
    );

endmodule

FILE: rtl/hpl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpl_checker
// Port-level checks on the Hall position linearizer, bound to the top level.
// ----------------------------------------------------------------------------
module hpl_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  o_in_stall,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic signed [hpl_pkg::POS_W-1:0]      o_position,
    input logic                                  o_saturated
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_position) && $stable(o_saturated))
        else $error("stalled result changed");

    a_sat_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            (o_position == hpl_pkg::POS_MAX || o_position == hpl_pkg::POS_MIN))
        else $error("saturated flag without rail value");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not idle after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> $past(o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

endmodule

bind hall_position_linearizer hpl_checker u_hpl_checker (.*);

FILE: sim/hpl_position_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpl_position_checker
// Watches the configuration, sample and position channels of the Hall
// position linearizer, keeps its own copy of the calibration registers,
// predicts the position and clip flag of every sample transfer and compares
// each position transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module hpl_position_checker #(
    parameter int FRAC_BITS = hpl_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  logic [hpl_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [hpl_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_stall,
    input  logic signed [hpl_pkg::Z_W-1:0]        i_raw_z,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_stall,
    input  logic signed [hpl_pkg::POS_W-1:0]      i_position,
    input  logic                                  i_saturated,
    input  logic                                  i_end_check,
    output int                                    o_pending,
    output int                                    o_fail_count
);

    typedef struct packed {
        logic signed [hpl_pkg::POS_W-1:0] position;
        logic                             saturated;
    } t_expected_pos;

    logic                            cfg_clutch;
    logic                            cfg_cal_valid;
    logic signed [hpl_pkg::Z_W-1:0]  cfg_lo;
    logic signed [hpl_pkg::Z_W-1:0]  cfg_hi;
    logic signed [hpl_pkg::Z_W-1:0]  cfg_mid;
    logic [15:0]                     cfg_stroke;

    t_expected_pos expected_positions[$];
    int            result_count;
    bit            end_checked;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        result_count = 0;
        end_checked  = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (o_fail_count < 40) begin
            $display("[%0t] position transfer %0d: %s", $realtime, result_count, what);
        end
        o_fail_count++;
    endtask

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Nearest integer, ties away from zero
    function automatic longint round_ratio(input longint num, input longint den);
        longint n;
        longint d;
        n = num;
        d = den;
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        if (n >= 0) begin
            return (2 * n + d) / (2 * d);
        end
        return -((-2 * n + d) / (2 * d));
    endfunction

    function automatic t_expected_pos predict_position(
        input logic signed [hpl_pkg::Z_W-1:0] raw);
        t_expected_pos res;
        longint z;
        longint lo;
        longint hi;
        longint mid;
        longint s;
        longint mm;
        longint val;
        longint n;
        longint d;
        logic   sat;
        z   = raw;
        lo  = cfg_lo;
        hi  = cfg_hi;
        mid = cfg_mid;
        s   = cfg_stroke;
        sat = 1'b0;
        n   = 0;
        d   = 1;
        if (cfg_clutch || !cfg_cal_valid) begin
            mm  = cfg_clutch ? hpl_pkg::CLUTCH_MM : hpl_pkg::GEAR_MM;
            val = round_ratio((z + hpl_pkg::FIX_OFFSET) * mm * (longint'(1) << FRAC_BITS),
                              hpl_pkg::FIX_SPAN);
        end else if (mid == 0 || magnitude(mid - lo) < hpl_pkg::MIN_GAP) begin
            if (magnitude(hi - lo) < hpl_pkg::MIN_GAP) begin
                val = 0;
            end else begin
                val = round_ratio((z - lo) * s, hi - lo);
            end
        end else if (lo < hi) begin
            if (z <= mid) begin
                val = round_ratio((z - lo) * s, 2 * (mid - lo));
            end else begin
                n   = z - mid;
                d   = hi - mid;
                val = 0;
            end
        end else begin
            if (z >= mid) begin
                val = round_ratio((lo - z) * s, 2 * (lo - mid));
            end else begin
                n   = mid - z;
                d   = mid - hi;
                val = 0;
            end
        end
        // Upper segment of the three-point map
        if (n != 0) begin
            if (d == 0) begin
                sat = 1'b1;
                val = hpl_pkg::POS_MAX;
            end else begin
                val = round_ratio(s * (d + n), 2 * d);
            end
        end
        if (val > hpl_pkg::POS_MAX) begin
            sat = 1'b1;
            val = hpl_pkg::POS_MAX;
        end else if (val < hpl_pkg::POS_MIN) begin
            sat = 1'b1;
            val = hpl_pkg::POS_MIN;
        end
        res.position  = val[hpl_pkg::POS_W-1:0];
        res.saturated = sat;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_expected_pos oldest;
        if (!i_rst_n) begin
            cfg_clutch    <= 1'b0;
            cfg_cal_valid <= 1'b0;
            cfg_lo        <= '0;
            cfg_hi        <= '0;
            cfg_mid       <= '0;
            cfg_stroke    <= hpl_pkg::STROKE_RST;
            expected_positions.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_positions.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, position %0d saturated %0b",
                                              i_position, i_saturated));
                end else begin
                    oldest = expected_positions.pop_front();
                    if (i_position !== oldest.position) begin
                        report_mismatch($sformatf("position %0d, expected %0d",
                                                  i_position, oldest.position));
                    end
                    if (i_saturated !== oldest.saturated) begin
                        report_mismatch($sformatf("saturated %0b, expected %0b",
                                                  i_saturated, oldest.saturated));
                    end
                end
                result_count++;
            end
            if (i_in_valid && !i_in_stall) begin
                expected_positions.push_back(predict_position(i_raw_z));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (hpl_pkg::t_reg_idx'(i_cfg_index))
                    hpl_pkg::REG_CLUTCH_KIND: cfg_clutch    <= i_cfg_data[0];
                    hpl_pkg::REG_CAL_VALID:   cfg_cal_valid <= i_cfg_data[0];
                    hpl_pkg::REG_Z_LOW:       cfg_lo        <= $signed(i_cfg_data);
                    hpl_pkg::REG_Z_HIGH:      cfg_hi        <= $signed(i_cfg_data);
                    hpl_pkg::REG_Z_MIDDLE:    cfg_mid       <= $signed(i_cfg_data);
                    hpl_pkg::REG_STROKE_LEN:  cfg_stroke    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_end_check && !end_checked) begin
                end_checked = 1'b1;
                if (expected_positions.size() != 0) begin
                    report_mismatch($sformatf("%0d expected results never arrived",
                                              expected_positions.size()));
                end
            end
        end
        o_pending = expected_positions.size();
    end

endmodule

FILE: sim/tb_hall_position_linearizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hall_position_linearizer
// Drives the Hall position linearizer through directed corner cases of the
// fixed, two-point and three-point maps, then through random calibration
// settings with random samples, random gaps on the sample side and random
// stalls on the position side, including one long output hold-off.
// ----------------------------------------------------------------------------
module tb_hall_position_linearizer;

    localparam int FRAC_BITS   = hpl_pkg::FRAC_BITS_DEF;
    localparam int STALL_LIMIT = 3000;
    localparam int FILL_HOLD   = 300;
    localparam int DRAIN_WAIT  = 40;
    localparam int Z_MIN       = -32768;
    localparam int Z_MAX       = 32767;
    localparam int STROKE_MAX  = 65535;
    localparam int FIX_OFFSET  = hpl_pkg::FIX_OFFSET;

    localparam logic [hpl_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [hpl_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [hpl_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [hpl_pkg::CFG_DATA_W-1:0]      i_cfg_data;
    logic                                i_in_valid;
    logic                                o_in_stall;
    logic signed [hpl_pkg::Z_W-1:0]      i_raw_z;
    logic                                o_out_valid;
    logic                                i_out_stall;
    logic signed [hpl_pkg::POS_W-1:0]    o_position;
    logic                                o_saturated;
    logic                                end_check;

    int pending;
    int fail_count;
    bit gaps_on;
    bit stalls_on;
    bit fill_req;
    bit fill_done;
    int pt_lo;
    int pt_hi;
    int pt_mid;

    hall_position_linearizer #(
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_raw_z     (i_raw_z),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_position  (o_position),
        .o_saturated (o_saturated)
    );

    hpl_position_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_raw_z      (i_raw_z),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_position   (o_position),
        .i_saturated  (o_saturated),
        .i_end_check  (end_check),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int clamp_z(input int v);
        if (v < Z_MIN) begin
            return Z_MIN;
        end
        if (v > Z_MAX) begin
            return Z_MAX;
        end
        return v;
    endfunction

    function automatic int pick_raw();
        int r;
        int base;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            return int'($urandom_range(0, STROKE_MAX)) + Z_MIN;
        end
        if (r < 8) begin
            case ($urandom_range(0, 4))
                0:       base = pt_lo;
                1:       base = pt_hi;
                2:       base = pt_mid;
                3:       base = -FIX_OFFSET;
                default: base = FIX_OFFSET;
            endcase
            return clamp_z(base + int'($urandom_range(0, 40)) - 20);
        end
        case ($urandom_range(0, 2))
            0:       return Z_MIN;
            1:       return Z_MAX;
            default: return 0;
        endcase
    endfunction

    task automatic send_sample(input int z);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_raw_z    <= hpl_pkg::Z_W'(z);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Leaves the channel valid so that back-to-back writes need no gap
    task automatic write_reg(input logic [hpl_pkg::CFG_IDX_W-1:0] idx, input int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= hpl_pkg::CFG_DATA_W'(data);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic apply_setting(input int ck, input int cv, input int lo, input int hi,
                                 input int mid, input int s);
        wait_drained();
        write_reg(hpl_pkg::REG_CLUTCH_KIND, ck);
        write_reg(hpl_pkg::REG_CAL_VALID, cv);
        write_reg(hpl_pkg::REG_Z_LOW, lo);
        write_reg(hpl_pkg::REG_Z_HIGH, hi);
        write_reg(hpl_pkg::REG_Z_MIDDLE, mid);
        write_reg(hpl_pkg::REG_STROKE_LEN, s);
        if ($urandom_range(0, 2) == 0) begin
            write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
        end
        i_cfg_valid <= 1'b0;
        pt_lo  = clamp_z(lo);
        pt_hi  = clamp_z(hi);
        pt_mid = clamp_z(mid);
    endtask

    task automatic random_setting();
        int shape;
        int lo;
        int hi;
        int mid;
        int s;
        int t;
        shape = $urandom_range(0, 8);
        lo    = int'($urandom_range(0, STROKE_MAX)) + Z_MIN;
        hi    = int'($urandom_range(0, STROKE_MAX)) + Z_MIN;
        mid   = int'($urandom_range(0, STROKE_MAX)) + Z_MIN;
        s     = $urandom_range(256, 12000);
        if ($urandom_range(0, 5) == 0) begin
            s = $urandom_range(0, 1) ? STROKE_MAX : 0;
        end
        case (shape)
            0: apply_setting(1, $urandom_range(0, 1), lo, hi, mid, s);
            1: apply_setting(0, 0, lo, hi, mid, s);
            2, 3: begin
                lo  = -int'($urandom_range(0, 30000));
                hi  = lo + int'($urandom_range(40, 32000));
                mid = lo + int'($urandom_range(10, hi - lo));
                if (shape == 3) begin
                    t  = lo;
                    lo = hi;
                    hi = t;
                end
                apply_setting(0, 1, lo, hi, mid, s);
            end
            4: begin
                mid = $urandom_range(0, 1) ? 0 : clamp_z(lo + int'($urandom_range(0, 18)) - 9);
                apply_setting(0, 1, lo, hi, mid, s);
            end
            5: begin
                hi  = clamp_z(lo + int'($urandom_range(0, 18)) - 9);
                mid = $urandom_range(0, 1) ? 0 : clamp_z(lo + int'($urandom_range(0, 18)) - 9);
                apply_setting(0, 1, lo, hi, mid, s);
            end
            6: apply_setting(0, 1, lo, mid, mid, s);
            7: begin
                lo = Z_MIN;
                hi = Z_MAX;
                case ($urandom_range(0, 3))
                    0:       mid = 0;
                    1:       mid = 1;
                    2:       mid = Z_MIN + 5;
                    default: mid = Z_MAX;
                endcase
                if ($urandom_range(0, 1)) begin
                    t  = lo;
                    lo = hi;
                    hi = t;
                end
                apply_setting(0, 1, lo, hi, mid, $urandom_range(0, 1) ? STROKE_MAX : s);
            end
            default: apply_setting(0, 1, lo, hi, mid, s);
        endcase
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            if (fill_req && !fill_done) begin
                i_out_stall <= 1'b1;
                repeat (FILL_HOLD) @(posedge i_clk);
                fill_done = 1'b1;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_cfg_valid && o_cfg_ready) || (i_in_valid && !o_in_stall) ||
                (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int n;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_raw_z     <= '0;
        end_check   <= 1'b0;
        gaps_on     = 1'b1;
        stalls_on   = 1'b1;
        fill_req    = 1'b0;
        fill_done   = 1'b0;
        pt_lo       = 0;
        pt_hi       = 0;
        pt_mid      = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: uncalibrated gear map, top end clips
        send_sample(Z_MIN);
        send_sample(Z_MAX);
        send_sample(-FIX_OFFSET);
        send_sample(0);

        // Clutch map wins over valid calibration
        apply_setting(1, 1, -1000, 3000, 500, 6656);
        send_sample(Z_MIN);
        send_sample(Z_MAX);
        send_sample(-FIX_OFFSET - 1);
        send_sample(FIX_OFFSET - 1);

        // Rising three-point map, widest stroke
        apply_setting(0, 1, -1000, 3000, 500, STROKE_MAX);
        send_sample(-1000);
        send_sample(500);
        send_sample(501);
        send_sample(3000);
        send_sample(Z_MAX);
        send_sample(Z_MIN);

        // Falling three-point map
        apply_setting(0, 1, 3000, -1000, 500, 6656);
        send_sample(3000);
        send_sample(499);
        send_sample(-1000);
        send_sample(Z_MIN);

        // Midpoint unused: two-point map
        apply_setting(0, 1, -500, 500, 0, 6656);
        send_sample(-500);
        send_sample(500);

        // Span too small
        apply_setting(0, 1, 100, 109, 0, 6656);
        send_sample(12345);

        // Midpoint too close to the low end
        apply_setting(0, 1, 1000, 5000, 1009, 6656);
        send_sample(3000);

        // Upper segment with zero divisor, both directions
        apply_setting(0, 1, -1000, 3000, 3000, 6656);
        send_sample(3001);
        apply_setting(0, 1, 1000, -500, -500, 6656);
        send_sample(-501);

        for (int ph = 0; ph < 18; ph++) begin
            random_setting();
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            n         = $urandom_range(40, 70);
            if (ph == 3) begin
                // Hold the output off while samples keep coming, to fill the pipe
                fill_req = 1'b1;
                gaps_on  = 1'b0;
                n        = 80;
            end
            if (ph >= 16) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            repeat (n) send_sample(pick_raw());
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
